/* rtl/uscp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uscp_pkg
// Shared types and constants of the serial set-command parser.
// ----------------------------------------------------------------------------
package uscp_pkg;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

    // Parser phases: prefix letters, then spaces, sign, digits, tail
    typedef enum logic [3:0] {
        PH_START   = 4'd0,
        PH_F_R     = 4'd1,
        PH_F_E     = 4'd2,
        PH_F_Q     = 4'd3,
        PH_EQ_F    = 4'd4,
        PH_P_E     = 4'd5,
        PH_P_R     = 4'd6,
        PH_P_I     = 4'd7,
        PH_P_O     = 4'd8,
        PH_P_D     = 4'd9,
        PH_EQ_P    = 4'd10,
        PH_SPACES  = 4'd11,
        PH_SIGNED  = 4'd12,
        PH_DIGITS  = 4'd13,
        PH_TAIL    = 4'd14,
        PH_FAIL    = 4'd15
    } t_phase;

    // Result status codes
    localparam logic [1:0] STS_FREQ    = 2'd0;
    localparam logic [1:0] STS_PERIOD  = 2'd1;
    localparam logic [1:0] STS_INVALID = 2'd2;

    // Command kinds
    localparam logic KIND_FREQ   = 1'b0;
    localparam logic KIND_PERIOD = 1'b1;

    // Characters
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TILDE = 8'd126;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_Q     = 8'h51;
    localparam logic [7:0] CH_R     = 8'h52;

    // Limits
    localparam logic [15:0] ACC_MAX   = 16'd65535;
    localparam logic [15:0] FREQ_MIN  = 16'd1;
    localparam logic [15:0] FREQ_MAX  = 16'd20000;
    localparam logic [15:0] PER_MIN   = 16'd100;
    localparam logic [15:0] PER_MAX   = 16'd10000;
    localparam logic [14:0] FREQ_RST  = 15'd1000;
    localparam logic [13:0] PER_RST   = 14'd2000;

    // Reload divider: 1000000 / freq, one quotient bit per step
    localparam int          DIV_STEPS    = 20;
    localparam logic [19:0] DIV_DIVIDEND = 20'd1000000;

    // Output word layout
    localparam int OUT_BITS = 72;

    // Controller to datapath
    typedef struct packed {
        logic start_div;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic freq_ok;
        logic div_last;
        logic out_busy;
    } t_dp_sts;

endpackage

/* rtl/uart_set_command_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_set_command_parser
// Parses FREQ= / PERIOD= command lines from received bytes and reports one
// result word per line end.
// ----------------------------------------------------------------------------
// Sequence: a line end's result word is loaded into the result register in
//   ST_EMIT once the previous word is taken; when a frequency is accepted,
//   ST_DIV first runs the 20 steps of the radix-2 reload divider.
// Throughput: one byte per cycle between line ends; the input is held after
//   a line end while the divider runs and the previous word is untaken.
// Reset: synchronous, active low; clears the line, sets 1000 Hz and 2000 ms.
// ----------------------------------------------------------------------------
module uart_set_command_parser #(
    parameter int LINE_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Received byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // Result word stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata    // [1:0] status, [16:2] set_value,
                                        // [36:17] reload_value,
                                        // [51:37] current_frequency,
                                        // [65:52] current_period, rest zero
);

    uscp_pkg::t_dp_cmd w_cmd;
    uscp_pkg::t_dp_sts w_sts;
    logic              w_eol;
    logic              w_ready;

    assign s_axis_tready = w_ready;

    // Sequencer: byte intake, divider run, hand-off to the output register
    uscp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_eol   (w_eol),
        .i_sts      (w_sts),
        .o_in_ready (w_ready),
        .o_cmd      (w_cmd)
    );

    // Parser, accumulator, divider and result register
    uscp_datapath #(
        .LINE_BYTES (LINE_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (s_axis_tvalid && w_ready),
        .i_in_byte   (s_axis_tdata),
        .i_cmd       (w_cmd),
        .i_out_ready (m_axis_tready),
        .o_in_eol    (w_eol),
        .o_sts       (w_sts),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

/* rtl/uscp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uscp_ctrl
// Sequencer: takes bytes, runs the reload divider, issues the result word.
// ----------------------------------------------------------------------------
module uscp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_eol,
    input  uscp_pkg::t_dp_sts i_sts,
    output logic              o_in_ready,
    output uscp_pkg::t_dp_cmd o_cmd
);

    uscp_pkg::t_state r_state;
    uscp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= uscp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_in_ready      = 1'b0;
        o_cmd.start_div = 1'b0;
        o_cmd.div_step  = 1'b0;
        o_cmd.load_out  = 1'b0;
        unique case (r_state)
            uscp_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && i_in_eol) begin
                    if (i_sts.freq_ok) begin
                        o_cmd.start_div = 1'b1;
                        n_state         = uscp_pkg::ST_DIV;
                    end else begin
                        n_state = uscp_pkg::ST_EMIT;
                    end
                end
            end
            uscp_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = uscp_pkg::ST_EMIT;
                end
            end
            uscp_pkg::ST_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = uscp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = uscp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/uscp_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uscp_datapath
// Line parser, number accumulator, reload divider and result register.
// ----------------------------------------------------------------------------
module uscp_datapath #(
    parameter int LINE_BYTES = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_accept,
    input  logic [7:0]                    i_in_byte,
    input  uscp_pkg::t_dp_cmd             i_cmd,
    input  logic                          i_out_ready,
    output logic                          o_in_eol,
    output uscp_pkg::t_dp_sts             o_sts,
    output logic                          o_out_valid,
    output logic [uscp_pkg::OUT_BITS-1:0] o_out_data
);

    localparam int KW = $clog2(LINE_BYTES);
    localparam int CW = $clog2(uscp_pkg::DIV_STEPS);

    // Line state
    logic [KW-1:0]    r_kept;
    uscp_pkg::t_phase r_phase;
    uscp_pkg::t_phase n_phase;
    logic             r_kind;
    logic             n_kind;
    logic             r_neg;
    logic             n_neg;
    logic [15:0]      r_acc;
    logic [15:0]      n_acc;

    // Settings in force
    logic [14:0]      r_freq;
    logic [13:0]      r_per;

    // Divider
    logic [19:0]      r_quo;
    logic [14:0]      r_rem;
    logic [14:0]      r_dvs;
    logic [CW-1:0]    r_div_cnt;
    logic [15:0]      w_rem_sh;
    logic             w_qbit;

    // Result register
    logic                          r_out_valid;
    logic [uscp_pkg::OUT_BITS-1:0] r_out_data;

    logic             w_printable;
    logic             w_take;
    logic             w_digit;
    logic [3:0]       w_dval;
    logic [19:0]      w_acc_x10;
    logic             w_digit_seen;
    logic             w_freq_ok;
    logic             w_per_ok;
    logic [1:0]       w_status;
    logic [14:0]      w_set;
    logic [19:0]      w_reload;

    assign o_in_eol    = (i_in_byte == uscp_pkg::CH_LF) || (i_in_byte == uscp_pkg::CH_CR);
    assign w_printable = (i_in_byte >= uscp_pkg::CH_SPACE) && (i_in_byte <= uscp_pkg::CH_TILDE);
    assign w_take      = i_in_accept && w_printable && (r_kept < KW'(LINE_BYTES - 1));
    assign w_digit     = (i_in_byte >= uscp_pkg::CH_0) && (i_in_byte <= uscp_pkg::CH_9);
    assign w_dval      = 4'(i_in_byte - uscp_pkg::CH_0);
    assign w_acc_x10   = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {16'd0, w_dval};

    // Character step of the parser
    always_comb begin
        n_phase = r_phase;
        n_kind  = r_kind;
        n_neg   = r_neg;
        n_acc   = r_acc;
        unique case (r_phase) inside
            uscp_pkg::PH_START: begin
                if (i_in_byte == uscp_pkg::CH_F) begin
                    n_kind  = uscp_pkg::KIND_FREQ;
                    n_phase = uscp_pkg::PH_F_R;
                end else if (i_in_byte == uscp_pkg::CH_P) begin
                    n_kind  = uscp_pkg::KIND_PERIOD;
                    n_phase = uscp_pkg::PH_P_E;
                end else begin
                    n_phase = uscp_pkg::PH_FAIL;
                end
            end
            uscp_pkg::PH_F_R: n_phase = (i_in_byte == uscp_pkg::CH_R) ?
                                        uscp_pkg::PH_F_E : uscp_pkg::PH_FAIL;
            uscp_pkg::PH_F_E: n_phase = (i_in_byte == uscp_pkg::CH_E) ?
                                        uscp_pkg::PH_F_Q : uscp_pkg::PH_FAIL;
            uscp_pkg::PH_F_Q: n_phase = (i_in_byte == uscp_pkg::CH_Q) ?
                                        uscp_pkg::PH_EQ_F : uscp_pkg::PH_FAIL;
            uscp_pkg::PH_P_E: n_phase = (i_in_byte == uscp_pkg::CH_E) ?
                                        uscp_pkg::PH_P_R : uscp_pkg::PH_FAIL;
            uscp_pkg::PH_P_R: n_phase = (i_in_byte == uscp_pkg::CH_R) ?
                                        uscp_pkg::PH_P_I : uscp_pkg::PH_FAIL;
            uscp_pkg::PH_P_I: n_phase = (i_in_byte == uscp_pkg::CH_I) ?
                                        uscp_pkg::PH_P_O : uscp_pkg::PH_FAIL;
            uscp_pkg::PH_P_O: n_phase = (i_in_byte == uscp_pkg::CH_O) ?
                                        uscp_pkg::PH_P_D : uscp_pkg::PH_FAIL;
            uscp_pkg::PH_P_D: n_phase = (i_in_byte == uscp_pkg::CH_D) ?
                                        uscp_pkg::PH_EQ_P : uscp_pkg::PH_FAIL;
            uscp_pkg::PH_EQ_F,
            uscp_pkg::PH_EQ_P: n_phase = (i_in_byte == uscp_pkg::CH_EQ) ?
                                         uscp_pkg::PH_SPACES : uscp_pkg::PH_FAIL;
            uscp_pkg::PH_SPACES: begin
                if (i_in_byte == uscp_pkg::CH_SPACE) begin
                    n_phase = uscp_pkg::PH_SPACES;
                end else if (i_in_byte == uscp_pkg::CH_PLUS) begin
                    n_phase = uscp_pkg::PH_SIGNED;
                end else if (i_in_byte == uscp_pkg::CH_MINUS) begin
                    n_neg   = 1'b1;
                    n_phase = uscp_pkg::PH_SIGNED;
                end else if (w_digit) begin
                    n_phase = uscp_pkg::PH_DIGITS;
                end else begin
                    n_phase = uscp_pkg::PH_FAIL;
                end
            end
            uscp_pkg::PH_SIGNED: n_phase = w_digit ? uscp_pkg::PH_DIGITS : uscp_pkg::PH_FAIL;
            uscp_pkg::PH_DIGITS: n_phase = w_digit ? uscp_pkg::PH_DIGITS : uscp_pkg::PH_TAIL;
            default: n_phase = r_phase;
        endcase
        // Fold a digit into the accumulator, saturating
        if (w_digit && (r_phase == uscp_pkg::PH_SPACES || r_phase == uscp_pkg::PH_SIGNED ||
                        r_phase == uscp_pkg::PH_DIGITS)) begin
            n_acc = (w_acc_x10 > {4'd0, uscp_pkg::ACC_MAX}) ? uscp_pkg::ACC_MAX
                                                             : w_acc_x10[15:0];
        end
    end

    // Line verdict
    assign w_digit_seen = (r_phase == uscp_pkg::PH_DIGITS) || (r_phase == uscp_pkg::PH_TAIL);
    assign w_freq_ok = w_digit_seen && !r_neg && (r_kind == uscp_pkg::KIND_FREQ) &&
                       (r_acc >= uscp_pkg::FREQ_MIN) && (r_acc <= uscp_pkg::FREQ_MAX);
    assign w_per_ok  = w_digit_seen && !r_neg && (r_kind == uscp_pkg::KIND_PERIOD) &&
                       (r_acc >= uscp_pkg::PER_MIN) && (r_acc <= uscp_pkg::PER_MAX);

    always_comb begin
        if (w_freq_ok) begin
            w_status = uscp_pkg::STS_FREQ;
        end else if (w_per_ok) begin
            w_status = uscp_pkg::STS_PERIOD;
        end else begin
            w_status = uscp_pkg::STS_INVALID;
        end
    end

    assign w_set    = (w_freq_ok || w_per_ok) ? r_acc[14:0] : 15'd0;
    assign w_reload = w_freq_ok ? (r_quo - 20'd1) : 20'd0;

    // Restoring divider step
    assign w_rem_sh = {r_rem, r_quo[19]};
    assign w_qbit   = (w_rem_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_div) begin
            r_quo     <= uscp_pkg::DIV_DIVIDEND;
            r_rem     <= '0;
            r_dvs     <= r_acc[14:0];
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_quo     <= {r_quo[18:0], w_qbit};
            r_rem     <= w_qbit ? 15'(w_rem_sh - {1'b0, r_dvs}) : w_rem_sh[14:0];
            r_div_cnt <= r_div_cnt + CW'(1);
        end
    end

    // Line state and settings
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept  <= '0;
            r_phase <= uscp_pkg::PH_START;
            r_kind  <= uscp_pkg::KIND_FREQ;
            r_neg   <= 1'b0;
            r_acc   <= '0;
            r_freq  <= uscp_pkg::FREQ_RST;
            r_per   <= uscp_pkg::PER_RST;
        end else if (i_cmd.load_out) begin
            r_kept  <= '0;
            r_phase <= uscp_pkg::PH_START;
            r_kind  <= uscp_pkg::KIND_FREQ;
            r_neg   <= 1'b0;
            r_acc   <= '0;
            if (w_freq_ok) begin
                r_freq <= r_acc[14:0];
            end
            if (w_per_ok) begin
                r_per <= r_acc[13:0];
            end
        end else if (w_take) begin
            r_kept  <= r_kept + KW'(1);
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= {6'd0,
                           w_per_ok ? r_acc[13:0] : r_per,
                           w_freq_ok ? r_acc[14:0] : r_freq,
                           w_reload, w_set, w_status};
        end
    end

    assign o_sts.freq_ok  = w_freq_ok;
    assign o_sts.div_last = (r_div_cnt == CW'(uscp_pkg::DIV_STEPS - 1));
    assign o_sts.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;

endmodule
